// File: src/tza_pkg.sv
// Shared constants, codes and state encoding for the tagged zone allocator.
// No dependencies; every other source file except tza_hdr_mem imports this package.
package tza_pkg;

   localparam int OPCODE_W   = 3;
   localparam int SIZE_W     = 17;
   localparam int TAG_W      = 8;
   localparam int ADDR_W     = 12;
   localparam int STATUS_W   = 2;
   localparam int FREED_W    = 11;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 17;
   localparam int NEED_W     = 14;

   localparam int ARENA_GRANULES_DEF  = 4096;
   localparam int HEADER_GRANULES_DEF = 3;

   localparam logic [OPCODE_W-1:0] OP_ALLOC      = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_FREE       = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_FREE_TAG   = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_FREE_RANGE = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_CHANGE_TAG = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_OOM       = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOT_ALLOC = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_BAD_ADDR  = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_PURGE_LEVEL = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_FRAG    = 1'b1;

   localparam logic [TAG_W-1:0]      PURGE_LEVEL_RST = 8'd128;
   localparam logic [CSR_DATA_W-1:0] MAX_FRAG_RST    = 17'd64;

   typedef enum logic [4:0] {
      S_CLEAR,
      S_IDLE,
      S_AL_PRV,
      S_AL_INIT,
      S_AL_RC,
      S_AL_EV,
      S_AL_P1,
      S_AL_P2,
      S_AL_P3,
      S_AL_S1,
      S_AL_S2,
      S_LOC_EV,
      S_FM_EV,
      S_FM_NX,
      S_RL_P,
      S_RL_PF,
      S_RL_Q,
      S_RL_QF,
      S_RL_WM,
      S_RESP
   } state_type;

endpackage

// File: src/tza_req_if.sv
// Request channel of the tagged zone allocator: valid/ready plus one operation.
// Depends on tza_pkg for field widths.
interface tza_req_if import tza_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic [SIZE_W-1:0]   size_bytes;
   logic [TAG_W-1:0]    tag;
   logic [TAG_W-1:0]    tag_high;
   logic [ADDR_W-1:0]   address;

   modport source (output valid, opcode, size_bytes, tag, tag_high, address, input ready);
   modport sink   (input valid, opcode, size_bytes, tag, tag_high, address, output ready);
endinterface

// File: src/tza_rsp_if.sv
// Response channel of the tagged zone allocator: valid/ready plus one result.
// Depends on tza_pkg for field widths.
interface tza_rsp_if import tza_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [ADDR_W-1:0]   address_res;
   logic [STATUS_W-1:0] status;
   logic [FREED_W-1:0]  blocks_freed;

   modport source (output valid, address_res, status, blocks_freed, input ready);
   modport sink   (input valid, address_res, status, blocks_freed, output ready);
endinterface

// File: src/tza_hdr_mem.sv
// Block header store: one write port, one read port, registered read data.
// A read of the entry written in the same cycle returns the new data.
module tza_hdr_mem #(
   parameter int DEPTH = 4096,
   parameter int WIDTH = 49,
   parameter int IW    = 12
) (
   input  logic             clock,
   input  logic             we,
   input  logic [IW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [IW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (we && waddr == raddr) begin
         rdata_ff <= wdata;
      end else begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: src/tagged_zone_allocator.sv
// Tagged zone allocator: first-fit search from a roving pointer over an arena of 16-byte granules.
// req_ch carries one operation per beat (alloc, free, free by tag, free tag
// range, change tag); rsp_ch returns exactly one result beat per request.
// csr_we/csr_index/csr_data write purge_level and max_fragment_bytes; write
// them only while no request is in flight.
// Block headers live in one synchronous RAM; every list step is a read, then a
// modify and a write back. Requests are taken one at a time. An alloc walks
// the blocks from the rover, purging used blocks tagged at or above purge_level,
// and splits off a leftover above max_fragment_bytes; a free merges the block
// with free neighbours; change tag rewrites one header; an address out of range
// answers without a header read; free by tag / range walks every block.
// The next request is taken in the cycle in which the result turns valid.
// A finished result sits in the response register while rsp_ch stalls; the
// next request is still taken and processed, and its result holds until the
// register frees.
// After reset the header RAM is swept, one entry a cycle; req_ch.ready stays
// low until the sweep is done. CSR writes are taken at any time.
module tagged_zone_allocator import tza_pkg::*; #(
   parameter int ARENA_GRANULES  = ARENA_GRANULES_DEF,
   parameter int HEADER_GRANULES = HEADER_GRANULES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   tza_req_if.sink               req_ch,
   tza_rsp_if.source             rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int AW         = $clog2(ARENA_GRANULES + 1);
   localparam int MW         = $clog2(ARENA_GRANULES);
   localparam int WALK_LIMIT = 4 * (ARENA_GRANULES + 2);
   localparam int GW         = $clog2(WALK_LIMIT + 2);
   localparam int CW         = (AW > NEED_W) ? AW : NEED_W;
   localparam int LW         = (AW + 4 > CSR_DATA_W) ? AW + 4 : CSR_DATA_W;

   localparam logic [AW-1:0] END_NODE = AW'(ARENA_GRANULES);

   typedef struct packed {
      logic             head;
      logic             used;
      logic [TAG_W-1:0] tag;
      logic [AW-1:0]    size;
      logic [AW-1:0]    prev;
      logic [AW-1:0]    next;
   } hdr_type;

   localparam int REC_W = $bits(hdr_type);

   state_type           state_ff, state_in, ret_ff, ret_in;
   logic [MW-1:0]       clr_ff, clr_in;
   hdr_type             end_ff, end_in;
   logic                rd_end_ff;
   logic [AW-1:0]       rover_ff, rover_in;
   logic [TAG_W-1:0]    purge_ff;
   logic [CSR_DATA_W-1:0] frag_ff;

   logic [OPCODE_W-1:0] op_ff, op_in;
   logic [TAG_W-1:0]    tag_ff, tag_in, taghi_ff, taghi_in;
   logic [NEED_W-1:0]   need_ff, need_in;
   logic [AW-1:0]       base_ff, base_in, cur_ff, cur_in, start_ff, start_in;
   logic [AW-1:0]       n_ff, n_in, m_ff, m_in;
   hdr_type             bb_ff, bb_in, bn_ff, bn_in, bm_ff, bm_in;
   logic [GW-1:0]       guard_ff, guard_in;
   logic [FREED_W-1:0]  cnt_ff, cnt_in;
   logic [ADDR_W-1:0]   res_addr_ff, res_addr_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]   rsp_addr_ff, rsp_addr_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [FREED_W-1:0]  rsp_freed_ff, rsp_freed_in;

   logic                mem_we;
   logic [AW-1:0]       mem_wa, mem_ra;
   hdr_type             mem_wd, rd;
   logic [REC_W-1:0]    mem_rdata;

   // header RAM; the end marker is kept in end_ff
   tza_hdr_mem #(
      .DEPTH (ARENA_GRANULES),
      .WIDTH (REC_W),
      .IW    (MW)
   ) u_hdr_mem (
      .clock (clock),
      .we    (mem_we && mem_wa != END_NODE),
      .waddr (mem_wa[MW-1:0]),
      .wdata (mem_wd),
      .raddr (mem_ra[MW-1:0]),
      .rdata (mem_rdata)
   );

   assign rd = rd_end_ff ? end_ff : hdr_type'(mem_rdata);

   assign req_ch.ready       = (state_ff == S_IDLE);
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.address_res = rsp_addr_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.blocks_freed = rsp_freed_ff;

   logic [17:0]         round_up;
   logic [AW-1:0]       left;
   logic [AW-1:0]       nn;
   logic [AW-1:0]       cur_nx, base_nx;
   logic [GW-1:0]       guard_nx;
   logic [AW-1:0]       loc_h;
   logic                tag_hit;
   logic [FREED_W-1:0]  cnt_inc;

   always_comb begin
      round_up = {1'b0, req_ch.size_bytes} + 18'd15;
      left     = bb_ff.size - AW'(need_ff);
      nn       = base_ff + AW'(need_ff);
      guard_nx = guard_ff + 1'b1;
      loc_h    = AW'(32'(req_ch.address) - HEADER_GRANULES);
      cnt_inc  = (cnt_ff == '1) ? cnt_ff : cnt_ff + 1'b1;
      if (op_ff == OP_FREE_RANGE) begin
         tag_hit = rd.used && rd.tag > tag_ff && rd.tag < taghi_ff;
      end else begin
         tag_hit = rd.used && rd.tag == tag_ff;
      end
      cur_nx  = rd.next;
      base_nx = base_ff;

      state_in      = state_ff;
      ret_in        = ret_ff;
      clr_in        = clr_ff;
      end_in        = end_ff;
      rover_in      = rover_ff;
      op_in         = op_ff;
      tag_in        = tag_ff;
      taghi_in      = taghi_ff;
      need_in       = need_ff;
      base_in       = base_ff;
      cur_in        = cur_ff;
      start_in      = start_ff;
      n_in          = n_ff;
      m_in          = m_ff;
      bb_in         = bb_ff;
      bn_in         = bn_ff;
      bm_in         = bm_ff;
      guard_in      = guard_ff;
      cnt_in        = cnt_ff;
      res_addr_in   = res_addr_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      rsp_freed_in  = rsp_freed_ff;
      mem_we        = 1'b0;
      mem_wa        = '0;
      mem_wd        = '0;
      mem_ra        = '0;

      case (state_ff)
         S_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = AW'(clr_ff);
            if (clr_ff == '0) begin
               mem_wd.head = 1'b1;
               mem_wd.size = END_NODE;
               mem_wd.prev = END_NODE;
               mem_wd.next = END_NODE;
            end
            clr_in = clr_ff + 1'b1;
            if (clr_ff == MW'(ARENA_GRANULES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_ch.valid) begin
               op_in         = req_ch.opcode;
               tag_in        = req_ch.tag;
               taghi_in      = req_ch.tag_high;
               cnt_in        = '0;
               res_addr_in   = '0;
               res_status_in = STATUS_OK;
               need_in = NEED_W'(round_up[17:4]) + NEED_W'(HEADER_GRANULES);
               case (req_ch.opcode)
                  OP_ALLOC: begin
                     mem_ra   = rover_ff;
                     state_in = S_AL_PRV;
                  end
                  OP_FREE, OP_CHANGE_TAG: begin
                     if (32'(req_ch.address) < HEADER_GRANULES ||
                         32'(req_ch.address) - HEADER_GRANULES >= ARENA_GRANULES) begin
                        res_status_in = STATUS_BAD_ADDR;
                        state_in      = S_RESP;
                     end else begin
                        n_in     = loc_h;
                        mem_ra   = loc_h;
                        state_in = S_LOC_EV;
                     end
                  end
                  OP_FREE_TAG, OP_FREE_RANGE: begin
                     cur_in = end_ff.next;
                     mem_ra = end_ff.next;
                     if (end_ff.next == END_NODE) begin
                        state_in = S_RESP;
                     end else begin
                        state_in = S_FM_EV;
                     end
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end
         end
         // alloc: step back one block when the rover's predecessor is free
         S_AL_PRV: begin
            bn_in    = rd;
            mem_ra   = rd.prev;
            state_in = S_AL_INIT;
         end
         S_AL_INIT: begin
            if (!rd.used) begin
               base_in  = bn_ff.prev;
               start_in = rd.prev;
            end else begin
               base_in  = rover_ff;
               start_in = bn_ff.prev;
            end
            cur_in   = base_in;
            guard_in = '0;
            mem_ra   = base_in;
            state_in = S_AL_RC;
         end
         S_AL_RC: begin
            bb_in    = rd;
            mem_ra   = cur_ff;
            state_in = S_AL_EV;
         end
         S_AL_EV: begin
            if (!bb_ff.used && CW'(bb_ff.size) >= CW'(need_ff)) begin
               if (LW'(left) << 4 > LW'(frag_ff)) begin
                  mem_we      = 1'b1;
                  mem_wa      = nn;
                  mem_wd.head = 1'b1;
                  mem_wd.size = left;
                  mem_wd.prev = base_ff;
                  mem_wd.next = bb_ff.next;
                  mem_ra      = bb_ff.next;
                  state_in    = S_AL_S1;
               end else begin
                  mem_we      = 1'b1;
                  mem_wa      = base_ff;
                  mem_wd      = bb_ff;
                  mem_wd.used = 1'b1;
                  mem_wd.tag  = tag_ff;
                  rover_in    = bb_ff.next;
                  res_addr_in = ADDR_W'(32'(base_ff) + HEADER_GRANULES);
                  state_in    = S_RESP;
               end
            end else begin
               guard_in = guard_nx;
               if (rd.used && cur_ff != END_NODE && rd.tag >= purge_ff) begin
                  // purge: release cur, then rebuild base and cur from base.prev
                  base_in  = bb_ff.prev;
                  n_in     = cur_ff;
                  bn_in    = rd;
                  cnt_in   = cnt_inc;
                  ret_in   = S_AL_P1;
                  mem_ra   = rd.prev;
                  state_in = S_RL_P;
               end else begin
                  if (rd.used) begin
                     base_nx = rd.next;
                  end
                  cur_in  = cur_nx;
                  base_in = base_nx;
                  if (cur_nx == start_ff || 32'(guard_nx) > WALK_LIMIT) begin
                     res_status_in = STATUS_OOM;
                     state_in      = S_RESP;
                  end else begin
                     mem_ra   = base_nx;
                     state_in = S_AL_RC;
                  end
               end
            end
         end
         S_AL_P1: begin
            mem_ra   = base_ff;
            state_in = S_AL_P2;
         end
         S_AL_P2: begin
            base_in  = rd.next;
            mem_ra   = rd.next;
            state_in = S_AL_P3;
         end
         S_AL_P3: begin
            cur_in = rd.next;
            if (rd.next == start_ff || 32'(guard_ff) > WALK_LIMIT) begin
               res_status_in = STATUS_OOM;
               state_in      = S_RESP;
            end else begin
               mem_ra   = base_ff;
               state_in = S_AL_RC;
            end
         end
         S_AL_S1: begin
            mem_we      = 1'b1;
            mem_wa      = bb_ff.next;
            mem_wd      = rd;
            mem_wd.prev = nn;
            state_in    = S_AL_S2;
         end
         S_AL_S2: begin
            mem_we      = 1'b1;
            mem_wa      = base_ff;
            mem_wd      = bb_ff;
            mem_wd.used = 1'b1;
            mem_wd.tag  = tag_ff;
            mem_wd.size = AW'(need_ff);
            mem_wd.next = nn;
            rover_in    = nn;
            res_addr_in = ADDR_W'(32'(base_ff) + HEADER_GRANULES);
            state_in    = S_RESP;
         end
         S_LOC_EV: begin
            if (!rd.head) begin
               res_status_in = STATUS_BAD_ADDR;
               state_in      = S_RESP;
            end else if (!rd.used) begin
               res_status_in = STATUS_NOT_ALLOC;
               state_in      = S_RESP;
            end else if (op_ff == OP_FREE) begin
               cnt_in   = cnt_inc;
               bn_in    = rd;
               ret_in   = S_RESP;
               mem_ra   = rd.prev;
               state_in = S_RL_P;
            end else begin
               mem_we     = 1'b1;
               mem_wa     = n_ff;
               mem_wd     = rd;
               mem_wd.tag = tag_ff;
               state_in   = S_RESP;
            end
         end
         S_FM_EV: begin
            if (tag_hit) begin
               cnt_in   = cnt_inc;
               n_in     = cur_ff;
               bn_in    = rd;
               ret_in   = S_FM_NX;
               mem_ra   = rd.prev;
               state_in = S_RL_P;
            end else begin
               cur_in = rd.next;
               mem_ra = rd.next;
               if (rd.next == END_NODE) begin
                  state_in = S_RESP;
               end
            end
         end
         S_FM_NX: begin
            cur_in = bm_ff.next;
            mem_ra = bm_ff.next;
            if (bm_ff.next == END_NODE) begin
               state_in = S_RESP;
            end else begin
               state_in = S_FM_EV;
            end
         end
         // release n: rd holds its predecessor
         S_RL_P: begin
            mem_ra = bn_ff.next;
            if (!rd.used) begin
               mem_we      = 1'b1;
               mem_wa      = n_ff;
               mem_wd      = bn_ff;
               mem_wd.head = 1'b0;
               mem_wd.used = 1'b0;
               mem_wd.tag  = '0;
               m_in        = bn_ff.prev;
               bm_in       = rd;
               bm_in.size  = rd.size + bn_ff.size;
               bm_in.next  = bn_ff.next;
               if (rover_ff == n_ff) begin
                  rover_in = bn_ff.prev;
               end
               state_in = S_RL_PF;
            end else begin
               m_in      = n_ff;
               bm_in     = bn_ff;
               bm_in.used = 1'b0;
               bm_in.tag = '0;
               state_in  = S_RL_Q;
            end
         end
         S_RL_PF: begin
            mem_we      = 1'b1;
            mem_wa      = bn_ff.next;
            mem_wd      = rd;
            mem_wd.prev = bn_ff.prev;
            mem_ra      = bn_ff.next;
            state_in    = S_RL_Q;
         end
         S_RL_Q: begin
            if (!rd.used) begin
               mem_we      = 1'b1;
               mem_wa      = bm_ff.next;
               mem_wd      = rd;
               mem_wd.head = 1'b0;
               bm_in.size  = bm_ff.size + rd.size;
               bm_in.next  = rd.next;
               if (rover_ff == bm_ff.next) begin
                  rover_in = m_ff;
               end
               mem_ra   = rd.next;
               state_in = S_RL_QF;
            end else begin
               mem_we   = 1'b1;
               mem_wa   = m_ff;
               mem_wd   = bm_ff;
               state_in = ret_ff;
            end
         end
         S_RL_QF: begin
            mem_we      = 1'b1;
            mem_wa      = bm_ff.next;
            mem_wd      = rd;
            mem_wd.prev = m_ff;
            state_in    = S_RL_WM;
         end
         S_RL_WM: begin
            mem_we   = 1'b1;
            mem_wa   = m_ff;
            mem_wd   = bm_ff;
            state_in = ret_ff;
         end
         S_RESP: begin
            // hold until the response register is free
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = res_addr_ff;
               rsp_status_in = res_status_ff;
               rsp_freed_in  = cnt_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (mem_we && mem_wa == END_NODE) begin
         end_in = mem_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rover_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         purge_ff     <= PURGE_LEVEL_RST;
         frag_ff      <= MAX_FRAG_RST;
         end_ff       <= '{head: 1'b0, used: 1'b1, tag: '0, size: '0, prev: '0, next: '0};
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rover_ff     <= rover_in;
         rsp_valid_ff <= rsp_valid_in;
         end_ff       <= end_in;
         if (csr_we) begin
            case (csr_index)
               CSR_PURGE_LEVEL: purge_ff <= csr_data[TAG_W-1:0];
               CSR_MAX_FRAG:    frag_ff  <= csr_data;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_end_ff     <= (mem_ra == END_NODE);
      ret_ff        <= ret_in;
      op_ff         <= op_in;
      tag_ff        <= tag_in;
      taghi_ff      <= taghi_in;
      need_ff       <= need_in;
      base_ff       <= base_in;
      cur_ff        <= cur_in;
      start_ff      <= start_in;
      n_ff          <= n_in;
      m_ff          <= m_in;
      bb_ff         <= bb_in;
      bn_ff         <= bn_in;
      bm_ff         <= bm_in;
      guard_ff      <= guard_in;
      cnt_ff        <= cnt_in;
      res_addr_ff   <= res_addr_in;
      res_status_ff <= res_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_freed_ff  <= rsp_freed_in;
   end

   a_resp_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESP && rsp_valid_ff && !rsp_ch.ready) |=> state_ff == S_RESP)
      else $error("result dropped while response register busy");

   a_clear_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !req_ch.ready)
      else $error("request taken during header sweep");

   a_free_counts_one: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESP && op_ff == OP_FREE) |-> cnt_ff <= 1)
      else $error("single free reported more than one block");

   a_rover_range: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> rover_ff <= END_NODE)
      else $error("rover beyond end marker");

endmodule

// File: dv/tb_tagged_zone_allocator.sv
// Testbench for tagged_zone_allocator: directed and random operations over the arena,
// checked beat by beat against an in-bench allocator model held in a scoreboard class.
// Depends on tza_pkg, tza_req_if, tza_rsp_if and the tagged_zone_allocator RTL.
module tb_tagged_zone_allocator;
   timeunit 1ns;
   timeprecision 1ps;
   import tza_pkg::*;

   localparam int ARENA = ARENA_GRANULES_DEF;
   localparam int HDR = HEADER_GRANULES_DEF;
   localparam int END_BLK = ARENA;
   localparam int WALK_MAX = 4 * (ARENA + 2);
   localparam longint CYCLE_LIMIT = 10000000;

   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic [SIZE_W-1:0] size_bytes;
      logic [TAG_W-1:0] tag;
      logic [TAG_W-1:0] tag_high;
      logic [ADDR_W-1:0] address;
   } zone_op_type;

   typedef struct packed {
      logic [ADDR_W-1:0] address_res;
      logic [STATUS_W-1:0] status;
      logic [FREED_W-1:0] blocks_freed;
   } zone_res_type;

   class zone_scoreboard;
      bit is_head[0:ARENA];
      bit used[0:ARENA];
      bit [7:0] blk_tag[0:ARENA];
      int unsigned blk_size[0:ARENA];
      int unsigned prv[0:ARENA];
      int unsigned nxt[0:ARENA];
      int unsigned rover;
      int unsigned purge_level;
      int unsigned max_frag;
      zone_res_type pending[$];
      int errors, results, allocs_ok, ooms, freed_total;

      function void clear_arena();
         for (int i = 0; i <= ARENA; i++) begin
            is_head[i] = 0; used[i] = 0; blk_tag[i] = 0;
            blk_size[i] = 0; prv[i] = 0; nxt[i] = 0;
         end
         is_head[0] = 1; blk_size[0] = ARENA; prv[0] = END_BLK; nxt[0] = END_BLK;
         used[END_BLK] = 1;
         rover = 0; purge_level = PURGE_LEVEL_RST; max_frag = MAX_FRAG_RST;
      endfunction

      function void write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         if (idx == CSR_PURGE_LEVEL) purge_level = data[7:0];
         else if (idx == CSR_MAX_FRAG) max_frag = data;
      endfunction

      // free a block and coalesce; return the block now holding it
      function int unsigned release_blk(int unsigned n);
         int unsigned p, q;
         used[n] = 0; blk_tag[n] = 0;
         p = prv[n];
         if (!used[p]) begin
            blk_size[p] += blk_size[n];
            nxt[p] = nxt[n];
            prv[nxt[n]] = p;
            is_head[n] = 0;
            if (rover == n) rover = p;
            n = p;
         end
         q = nxt[n];
         if (!used[q]) begin
            blk_size[n] += blk_size[q];
            nxt[n] = nxt[q];
            prv[nxt[q]] = n;
            is_head[q] = 0;
            if (rover == q) rover = n;
         end
         return n;
      endfunction

      function logic [STATUS_W-1:0] find_blk(int unsigned addr, output int unsigned node);
         int unsigned h;
         node = 0;
         if (addr < HDR) return STATUS_BAD_ADDR;
         h = addr - HDR;
         if (h >= ARENA || !is_head[h]) return STATUS_BAD_ADDR;
         if (!used[h]) return STATUS_NOT_ALLOC;
         node = h;
         return STATUS_OK;
      endfunction

      function int unsigned free_tagged(int unsigned lo, int unsigned hi, bit range);
         int unsigned cur, nx, cnt, guard;
         bit hit;
         cur = nxt[END_BLK]; cnt = 0; guard = 0;
         while (cur != END_BLK && guard < WALK_MAX) begin
            guard++;
            nx = nxt[cur];
            if (used[cur]) begin
               hit = range ? (blk_tag[cur] > lo && blk_tag[cur] < hi) : (blk_tag[cur] == lo);
               if (hit) begin
                  nx = nxt[release_blk(cur)];
                  cnt++;
               end
            end
            cur = nx;
         end
         return cnt;
      endfunction

      function zone_res_type predict(zone_op_type op);
         zone_res_type r;
         int unsigned need, base, cur, start, guard, left, nn, node, freed;
         bit fail;
         r = '0; freed = 0;
         case (op.opcode)
            OP_ALLOC: begin
               need = ((int'(op.size_bytes) + 15) >> 4) + HDR;
               base = rover;
               if (!used[prv[base]]) base = prv[base];
               cur = base; start = prv[base]; guard = 0; fail = 0;
               while (used[base] || blk_size[base] < need) begin
                  if (used[cur]) begin
                     if (cur != END_BLK && blk_tag[cur] >= purge_level) begin
                        base = prv[base];
                        void'(release_blk(cur));
                        freed++;
                        base = nxt[base];
                        cur = nxt[base];
                     end else begin
                        cur = nxt[cur];
                        base = cur;
                     end
                  end else
                     cur = nxt[cur];
                  guard++;
                  if (cur == start || guard > WALK_MAX) begin
                     fail = 1;
                     break;
                  end
               end
               if (fail)
                  r.status = STATUS_OOM;
               else begin
                  left = blk_size[base] - need;
                  if (left * 16 > max_frag) begin
                     nn = base + need;
                     is_head[nn] = 1; used[nn] = 0; blk_tag[nn] = 0;
                     blk_size[nn] = left; prv[nn] = base; nxt[nn] = nxt[base];
                     prv[nxt[base]] = nn;
                     nxt[base] = nn;
                     blk_size[base] = need;
                  end
                  used[base] = 1;
                  blk_tag[base] = op.tag;
                  rover = nxt[base];
                  r.address_res = ADDR_W'(base + HDR);
               end
            end
            OP_FREE: begin
               r.status = find_blk(op.address, node);
               if (r.status == STATUS_OK) begin
                  void'(release_blk(node));
                  freed = 1;
               end
            end
            OP_FREE_TAG: freed = free_tagged(op.tag, 0, 0);
            OP_FREE_RANGE: freed = free_tagged(op.tag, op.tag_high, 1);
            OP_CHANGE_TAG: begin
               r.status = find_blk(op.address, node);
               if (r.status == STATUS_OK) blk_tag[node] = op.tag;
            end
            default: ;
         endcase
         r.blocks_freed = (freed > 2047) ? 11'd2047 : freed[FREED_W-1:0];
         return r;
      endfunction

      function void note(zone_op_type op);
         pending.push_back(predict(op));
      endfunction

      // payload address of some live block, or a random one if none is live
      function logic [ADDR_W-1:0] live_address();
         int unsigned s, k;
         s = $urandom_range(ARENA - 1);
         for (int i = 0; i < ARENA; i++) begin
            k = (s + i) % ARENA;
            if (is_head[k] && used[k]) return ADDR_W'(k + HDR);
         end
         return ADDR_W'($urandom_range(4095));
      endfunction

      task report(string what, int unsigned got, int unsigned want);
         errors++;
         $display("MISMATCH %s: got %0d, expected %0d (result %0d)", what, got, want, results);
      endtask

      task check(zone_res_type got);
         zone_res_type want;
         if (pending.size() == 0) begin
            report("unexpected result beat", 1, 0);
            return;
         end
         want = pending.pop_front();
         if (got.address_res !== want.address_res)
            report("address_res", got.address_res, want.address_res);
         if (got.status !== want.status) report("status", got.status, want.status);
         if (got.blocks_freed !== want.blocks_freed)
            report("blocks_freed", got.blocks_freed, want.blocks_freed);
         results++;
         freed_total += want.blocks_freed;
         if (want.status == STATUS_OOM) ooms++;
         else if (want.address_res != 0) allocs_ok++;
      endtask
   endclass

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_data;
   tza_req_if req();
   tza_rsp_if rsp();
   zone_scoreboard sb;
   int tx_idle_pct, rx_idle_pct;
   longint cycles;

   tagged_zone_allocator uut (
      .clock(clock), .reset(reset), .req_ch(req), .rsp_ch(rsp),
      .csr_we(csr_we), .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   initial begin
      sb = new();
      sb.clear_arena();
      reset = 1; csr_we = 0; csr_index = '0; csr_data = '0;
      req.valid = 0; req.opcode = '0; req.size_bytes = '0;
      req.tag = '0; req.tag_high = '0; req.address = '0;
      rsp.ready = 0;
      tx_idle_pct = 0; rx_idle_pct = 0;
   end

   always @(negedge clock) rsp.ready <= ($urandom_range(99) >= rx_idle_pct);

   always @(posedge clock) begin
      cycles <= reset ? 0 : cycles + 1;
      if (!reset && rsp.valid && rsp.ready)
         sb.check({rsp.address_res, rsp.status, rsp.blocks_freed});
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("tb_tagged_zone_allocator: errors");
         $finish;
      end
   end

   task csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_we = 1; csr_index = idx; csr_data = data;
      @(negedge clock);
      csr_we = 0;
      sb.write_csr(idx, data);
   endtask

   // called at a falling edge; returns at the falling edge after the beat
   task send(logic [OPCODE_W-1:0] opc, logic [SIZE_W-1:0] sz, logic [TAG_W-1:0] tg,
             logic [TAG_W-1:0] th, logic [ADDR_W-1:0] ad);
      zone_op_type op;
      while ($urandom_range(99) < tx_idle_pct) begin
         req.valid = 0;
         @(negedge clock);
      end
      op = '{opcode: opc, size_bytes: sz, tag: tg, tag_high: th, address: ad};
      req.opcode = opc; req.size_bytes = sz; req.tag = tg;
      req.tag_high = th; req.address = ad; req.valid = 1;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      sb.note(op);
      @(negedge clock);
   endtask

   task drain();
      req.valid = 0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task random_op();
      int unsigned pick;
      logic [SIZE_W-1:0] sz;
      logic [TAG_W-1:0] tg;
      pick = $urandom_range(99);
      tg = ($urandom_range(3) == 0) ? TAG_W'($urandom_range(255)) :
                                      TAG_W'($urandom_range(15) + 120);
      if (pick < 40) begin
         sz = ($urandom_range(19) == 0) ? SIZE_W'($urandom_range(131071)) :
                                          SIZE_W'($urandom_range(400));
         send(OP_ALLOC, sz, tg, TAG_W'($urandom_range(255)), ADDR_W'($urandom_range(4095)));
      end else if (pick < 63)
         send(OP_FREE, SIZE_W'($urandom_range(131071)), tg, TAG_W'($urandom_range(255)),
              sb.live_address());
      else if (pick < 68)
         send(OP_FREE, SIZE_W'($urandom_range(131071)), tg, TAG_W'($urandom_range(255)),
              ADDR_W'($urandom_range(4095)));
      else if (pick < 76)
         send(OP_FREE_TAG, SIZE_W'($urandom_range(131071)), tg, TAG_W'($urandom_range(255)),
              ADDR_W'($urandom_range(4095)));
      else if (pick < 83)
         send(OP_FREE_RANGE, SIZE_W'($urandom_range(131071)), tg,
              TAG_W'(tg + $urandom_range(12)), ADDR_W'($urandom_range(4095)));
      else if (pick < 95)
         send(OP_CHANGE_TAG, SIZE_W'($urandom_range(131071)), tg, TAG_W'($urandom_range(255)),
              ($urandom_range(4) == 0) ? ADDR_W'($urandom_range(4095)) : sb.live_address());
      else
         send(OPCODE_W'($urandom_range(7, 5)), SIZE_W'($urandom_range(131071)),
              TAG_W'($urandom_range(255)), TAG_W'($urandom_range(255)),
              ADDR_W'($urandom_range(4095)));
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // phase 1: reset-like settings, sender faster than receiver
      csr_write(CSR_PURGE_LEVEL, 17'd128);
      csr_write(CSR_MAX_FRAG, 17'd64);
      tx_idle_pct = 34; rx_idle_pct = 47;
      send(OP_ALLOC, 17'd0, 8'd0, 8'd0, 12'd0);
      send(OP_ALLOC, 17'd1, 8'd255, 8'd0, 12'd0);
      send(OP_ALLOC, 17'd15, 8'd5, 8'd0, 12'd0);
      send(OP_ALLOC, 17'd16, 8'd6, 8'd0, 12'd0);
      send(OP_ALLOC, 17'd17, 8'd7, 8'd0, 12'd0);
      send(OP_ALLOC, 17'd65536, 8'd1, 8'd0, 12'd0);
      send(OP_ALLOC, 17'h1FFFF, 8'd1, 8'hFF, 12'hFFF);
      send(OP_FREE, 17'd0, 8'd0, 8'd0, 12'd0);
      send(OP_FREE, 17'd0, 8'd0, 8'd0, 12'd4095);
      send(OP_FREE, 17'd0, 8'd0, 8'd0, 12'd4);
      send(OP_CHANGE_TAG, 17'd0, 8'd128, 8'd0, 12'd6);
      send(OP_FREE, 17'd0, 8'd0, 8'd0, 12'd3);
      send(OP_FREE, 17'd0, 8'd0, 8'd0, 12'd3);
      send(OP_CHANGE_TAG, 17'd0, 8'd9, 8'd0, 12'd3);
      send(OP_CHANGE_TAG, 17'd0, 8'd9, 8'd0, 12'd2);
      send(OP_FREE_TAG, 17'd0, 8'd7, 8'd0, 12'd0);
      send(OP_FREE_RANGE, 17'd0, 8'd0, 8'd255, 12'd0);
      send(OP_FREE_RANGE, 17'd0, 8'd200, 8'd100, 12'd0);
      send(OP_ALLOC, 17'd4000, 8'd200, 8'd0, 12'd0);
      send(OP_ALLOC, 17'd32, 8'd3, 8'd0, 12'd0);
      send(3'd5, 17'h1FFFF, 8'hFF, 8'hFF, 12'hFFF);
      send(3'd6, 17'd0, 8'd0, 8'd0, 12'd0);
      send(3'd7, 17'd0, 8'd0, 8'd0, 12'd0);
      repeat (280) random_op();
      drain();

      // phase 2: purge only tag 255, split every leftover; sender slower
      csr_write(CSR_PURGE_LEVEL, 17'd255);
      csr_write(CSR_MAX_FRAG, 17'd0);
      tx_idle_pct = 47; rx_idle_pct = 34;
      repeat (120) random_op();
      // hold until every outstanding result is back
      req.valid = 0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (130) random_op();
      drain();

      // phase 3: purge everything walked over, never split
      csr_write(CSR_PURGE_LEVEL, 17'd0);
      csr_write(CSR_MAX_FRAG, 17'd65536);
      tx_idle_pct = 0; rx_idle_pct = 0;
      repeat (120) random_op();
      drain();

      // phase 4: middle settings, full rate
      csr_write(CSR_PURGE_LEVEL, 17'd130);
      csr_write(CSR_MAX_FRAG, 17'd256);
      repeat (150) random_op();
      drain();

      $display("covered %0d results: %0d allocations, %0d out-of-memory, %0d blocks freed",
               sb.results, sb.allocs_ok, sb.ooms, sb.freed_total);
      $display("settings swept: purge level 128/255/0/130, fragment limit 64/0/65536/256");
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("tb_tagged_zone_allocator: clean");
      else
         $display("tb_tagged_zone_allocator: errors");
      $finish;
   end
endmodule

// File: filelist.f
src/tza_pkg.sv
src/tza_req_if.sv
src/tza_rsp_if.sv
src/tza_hdr_mem.sv
src/tagged_zone_allocator.sv
dv/tb_tagged_zone_allocator.sv
